/* sv/iirl_pkg.sv */
// ----------------------------------------------------------------------------
// iirl_pkg
// Shared codes and types of the indexed insert/remove list: request modes,
// status codes and the per-cell command.
// ----------------------------------------------------------------------------
package iirl_pkg;

   localparam int MODE_BITS   = 2;
   localparam int POS_BITS    = 5;
   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 5;

   localparam logic [MODE_BITS-1:0] MODE_READ   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_WRITE  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_LOAD  = 2'd1;
   localparam logic [1:0] CELL_LEFT  = 2'd2;
   localparam logic [1:0] CELL_RIGHT = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic       rd_sel;
   } cell_cmd_type;

endpackage

/* sv/iirl_cell.sv */
// ----------------------------------------------------------------------------
// iirl_cell
// One list slot: holds a word, loads a new word, or takes the word of its
// lower or upper neighbor; drives its word onto the read tap when selected.
// ----------------------------------------------------------------------------
module iirl_cell import iirl_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  cell_cmd_type         cmd,
   input  logic [WORD_BITS-1:0] left_data,
   input  logic [WORD_BITS-1:0] right_data,
   input  logic [WORD_BITS-1:0] load_data,
   output logic [WORD_BITS-1:0] data,
   output logic [WORD_BITS-1:0] tap
);

   logic [WORD_BITS-1:0] data_ff;

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         CELL_HOLD:  data_ff <= data_ff;
         CELL_LOAD:  data_ff <= load_data;
         CELL_LEFT:  data_ff <= left_data;
         CELL_RIGHT: data_ff <= right_data;
      endcase
   end

   assign data = data_ff;
   assign tap  = cmd.rd_sel ? data_ff : '0;

endmodule

/* sv/indexed_insert_remove_list_top.sv */
// The response is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle unless stalled; all cells shift at once.
// The read path is an OR over the selected cell taps of the row.
// Reset clears the entry count and the response valid; cell contents are
// left undefined and are never read before being written.
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_top
// Fixed-capacity ordered list with read, overwrite, insert and remove at an
// index, built as a chain of cells that shift up or down together.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_top import iirl_pkg::*; #(
   parameter int CAPACITY  = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [MODE_BITS-1:0]   req_mode,
   input  logic [POS_BITS-1:0]    req_position,
   input  logic [VALUE_BITS-1:0]  req_item_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_BITS-1:0]  rsp_read_value,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [COUNT_BITS-1:0]  rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]  rsp_read_value_ff, rsp_read_value_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_BITS-1:0]  rsp_entry_count_ff, rsp_entry_count_in;

   logic                   accept;
   logic [CMP_W-1:0]       pos_w, cnt_w;
   logic                   full, in_range, ins_ok;
   logic [WORD_BITS-1:0]   load_word, rd_word;

   cell_cmd_type           cmd   [CAPACITY];
   logic [WORD_BITS-1:0]   cdata [CAPACITY];
   logic [WORD_BITS-1:0]   ctap  [CAPACITY];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign pos_w    = CMP_W'(req_position);
   assign cnt_w    = CMP_W'(cnt_ff);
   assign full     = (cnt_ff == CNT_W'(CAPACITY));
   assign in_range = (pos_w < cnt_w);
   assign ins_ok   = ~full & (pos_w <= cnt_w);

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         load_word[b] = (b < VALUE_BITS) ? req_item_value[b % VALUE_BITS] : 1'b0;
      end
   end

   // per-cell commands
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cmd[i].op     = CELL_HOLD;
         cmd[i].rd_sel = (CMP_W'(i) == pos_w);
         if (accept) begin
            unique case (req_mode)
               MODE_READ: begin
                  cmd[i].op = CELL_HOLD;
               end
               MODE_WRITE: begin
                  if (in_range && CMP_W'(i) == pos_w) cmd[i].op = CELL_LOAD;
               end
               MODE_INSERT: begin
                  if (ins_ok) begin
                     if (CMP_W'(i) == pos_w) begin
                        cmd[i].op = CELL_LOAD;
                     end else if (CMP_W'(i) > pos_w && CMP_W'(i) <= cnt_w) begin
                        cmd[i].op = CELL_LEFT;
                     end
                  end
               end
               MODE_REMOVE: begin
                  if (in_range && CMP_W'(i) >= pos_w && CMP_W'(i + 1) < cnt_w) begin
                     cmd[i].op = CELL_RIGHT;
                  end
               end
            endcase
         end
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_BITS-1:0] left_w, right_w;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cdata[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cdata[g+1];
      end
      iirl_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd[g]),
         .left_data  (left_w),
         .right_data (right_w),
         .load_data  (load_word),
         .data       (cdata[g]),
         .tap        (ctap[g])
      );
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_word = rd_word | ctap[i];
      end
   end

   // response and next count
   always_comb begin
      cnt_in            = cnt_ff;
      rsp_status_in     = STATUS_OK;
      rsp_read_value_in = '0;
      unique case (req_mode)
         MODE_READ: begin
            if (in_range) begin
               for (int b = 0; b < VALUE_BITS; b++) begin
                  rsp_read_value_in[b] = (b < WORD_BITS) ? rd_word[b % WORD_BITS] : 1'b0;
               end
            end else begin
               rsp_status_in = STATUS_RANGE;
            end
         end
         MODE_WRITE: begin
            if (!in_range) rsp_status_in = STATUS_RANGE;
         end
         MODE_INSERT: begin
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end else if (!ins_ok) begin
               rsp_status_in = STATUS_RANGE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         MODE_REMOVE: begin
            if (in_range) begin
               for (int b = 0; b < VALUE_BITS; b++) begin
                  rsp_read_value_in[b] = (b < WORD_BITS) ? rd_word[b % WORD_BITS] : 1'b0;
               end
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               rsp_status_in = STATUS_RANGE;
            end
         end
      endcase
      for (int b = 0; b < COUNT_BITS; b++) begin
         rsp_entry_count_in[b] = (b < CNT_W) ? cnt_in[b % CNT_W] : 1'b0;
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff  <= rsp_read_value_in;
         rsp_status_ff      <= rsp_status_in;
         rsp_entry_count_ff <= rsp_entry_count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_INSERT && ins_ok |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("accepted insert did not grow the list");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |-> rsp_read_value_ff == '0)
      else $error("error response carries data");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_INSERT && full |=> rsp_status_ff == STATUS_FULL
         && cnt_ff == $past(cnt_ff))
      else $error("insert into full list not refused");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");
`endif

endmodule
